/* hdl/adsr_pkg.sv */
package adsr_pkg;

    // field widths
    localparam int LevelWidth     = 15;
    localparam int EnvWidth       = 16;
    localparam int StepWidth      = 15;
    localparam int SustainWidth   = 8;
    localparam int SustainShift   = 7;
    localparam int StageCodeWidth = 2;
    localparam int CfgIndexWidth  = 2;
    localparam int CfgDataWidth   = 15;

    // level limits
    localparam logic [LevelWidth-1:0] LevelMax  = 15'h7fff;
    localparam logic [LevelWidth-1:0] LevelZero = 15'h0000;

    // register indexes
    localparam logic [CfgIndexWidth-1:0] REG_ATTACK_STEP   = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_DECAY_STEP    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_SUSTAIN_LEVEL = 2'd2;
    localparam logic [CfgIndexWidth-1:0] REG_RELEASE_STEP  = 2'd3;

    // register reset values
    localparam logic [StepWidth-1:0]    AttackStepReset   = 15'd64;
    localparam logic [StepWidth-1:0]    DecayStepReset    = 15'd64;
    localparam logic [SustainWidth-1:0] SustainLevelReset = 8'd128;
    localparam logic [StepWidth-1:0]    ReleaseStepReset  = 15'd64;

    // external stage codes
    localparam logic [StageCodeWidth-1:0] CODE_IDLE    = 2'd0;
    localparam logic [StageCodeWidth-1:0] CODE_ATTACK  = 2'd1;
    localparam logic [StageCodeWidth-1:0] CODE_DECAY   = 2'd2;
    localparam logic [StageCodeWidth-1:0] CODE_RELEASE = 2'd3;

    typedef enum logic [3:0] {
        STAGE_IDLE    = 4'b0001,
        STAGE_ATTACK  = 4'b0010,
        STAGE_DECAY   = 4'b0100,
        STAGE_RELEASE = 4'b1000
    } stage_t;

    typedef struct packed {
        logic [StepWidth-1:0]    attack_step;
        logic [StepWidth-1:0]    decay_step;
        logic [SustainWidth-1:0] sustain_level;
        logic [StepWidth-1:0]    release_step;
    } cfg_t;

    typedef struct packed {
        stage_t                stage;
        logic [LevelWidth-1:0] level;
        logic                  gate;
    } env_state_t;

    function automatic logic [StageCodeWidth-1:0] stage_code(input stage_t s);
        logic [StageCodeWidth-1:0] code;
        case (s)
            STAGE_ATTACK:  code = CODE_ATTACK;
            STAGE_DECAY:   code = CODE_DECAY;
            STAGE_RELEASE: code = CODE_RELEASE;
            default:       code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

/* hdl/adsr_cfg_regs.sv */
module adsr_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [adsr_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [adsr_pkg::CfgDataWidth-1:0]    cfg_data,
    output adsr_pkg::cfg_t                       cfg
);
    import adsr_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register write on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_step   <= AttackStepReset;
            cfg_reg.decay_step    <= DecayStepReset;
            cfg_reg.sustain_level <= SustainLevelReset;
            cfg_reg.release_step  <= ReleaseStepReset;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ATTACK_STEP:   cfg_reg.attack_step   <= cfg_data[StepWidth-1:0];
                REG_DECAY_STEP:    cfg_reg.decay_step    <= cfg_data[StepWidth-1:0];
                REG_SUSTAIN_LEVEL: cfg_reg.sustain_level <= cfg_data[SustainWidth-1:0];
                REG_RELEASE_STEP:  cfg_reg.release_step  <= cfg_data[StepWidth-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* hdl/adsr_step.sv */
module adsr_step (
    input  adsr_pkg::cfg_t       cfg,
    input  adsr_pkg::env_state_t cur,
    input  logic                 gate,
    output adsr_pkg::env_state_t nxt
);
    import adsr_pkg::*;

    stage_t                 entry_stage;
    logic [LevelWidth:0]    add_sum;
    logic [LevelWidth:0]    decay_diff;
    logic [LevelWidth:0]    release_diff;
    logic [LevelWidth:0]    target;

    // gate edges pick the stage before the level moves
    always_comb begin
        entry_stage = cur.stage;
        if (gate && !cur.gate) begin
            entry_stage = STAGE_ATTACK;
        end else if (!gate && cur.gate) begin
            entry_stage = STAGE_RELEASE;
        end
    end

    // 16-bit sums so that bit 15 flags overflow or underflow
    assign add_sum      = {1'b0, cur.level} + {1'b0, cfg.attack_step};
    assign decay_diff   = {1'b0, cur.level} - {1'b0, cfg.decay_step};
    assign release_diff = {1'b0, cur.level} - {1'b0, cfg.release_step};
    assign target       = {1'b0, cfg.sustain_level, {SustainShift{1'b0}}};

    // level update per stage
    always_comb begin
        nxt.gate  = gate;
        nxt.stage = entry_stage;
        nxt.level = LevelZero;
        case (entry_stage)
            STAGE_ATTACK: begin
                if (add_sum[LevelWidth]) begin
                    nxt.level = LevelMax;
                    nxt.stage = STAGE_DECAY;
                end else begin
                    nxt.level = add_sum[LevelWidth-1:0];
                end
            end
            STAGE_DECAY: begin
                if (decay_diff[LevelWidth] || decay_diff <= target) begin
                    nxt.level = target[LevelWidth-1:0];
                end else begin
                    nxt.level = decay_diff[LevelWidth-1:0];
                end
            end
            STAGE_RELEASE: begin
                if (release_diff[LevelWidth]) begin
                    nxt.level = LevelZero;
                    nxt.stage = STAGE_IDLE;
                end else begin
                    nxt.level = release_diff[LevelWidth-1:0];
                end
            end
            default: begin
                nxt.level = LevelZero;
            end
        endcase
    end

endmodule

/* hdl/adsr_envelope_generator.sv */
// path: an input transfer reaches its result through the input register, then the result register
// throughput: one tick per cycle while m_ready stays high
// the level update is one add or subtract and clamp between the two registers
// reset: synchronous active-low aresetn clears stage to idle, level and gate history to zero,
// empties both registers and loads the step and sustain registers with their defaults
module adsr_envelope_generator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_gate,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [adsr_pkg::EnvWidth-1:0]         m_envelope,
    output logic [adsr_pkg::StageCodeWidth-1:0]   m_stage,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [adsr_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [adsr_pkg::CfgDataWidth-1:0]     cfg_data
);
    import adsr_pkg::*;

    cfg_t       cfg;
    env_state_t state_reg;
    env_state_t state_next;

    logic                      in_valid_reg;
    logic                      gate_reg;
    logic                      out_valid_reg;
    logic [EnvWidth-1:0]       envelope_reg;
    logic [StageCodeWidth-1:0] stage_code_reg;
    logic                      advance;
    logic                      move;

    adsr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adsr_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .gate (gate_reg),
        .nxt  (state_next)
    );

    // handshake: result register frees, input register refills in the same cycle
    assign advance = !out_valid_reg || m_ready;
    assign move    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            gate_reg <= s_gate;
        end
    end

    // envelope state commits when a tick reaches the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.stage <= STAGE_IDLE;
            state_reg.level <= LevelZero;
            state_reg.gate  <= 1'b0;
        end else if (move) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            envelope_reg   <= {state_next.level, 1'b0};
            stage_code_reg <= stage_code(state_next.stage);
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_envelope = envelope_reg;
    assign m_stage    = stage_code_reg;

    // checks
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stage == CODE_IDLE) |-> (m_envelope == '0))
        else $error("idle result with non-zero envelope");

    a_env_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_envelope[0])
        else $error("envelope low bit set");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(gate_reg)))
        else $error("input register lost a tick under stall");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !move |=> $stable(state_reg))
        else $error("envelope state changed without a tick");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !in_valid_reg))
        else $error("registers not empty after reset");

endmodule
